>>> rtl/wf3_pkg.sv
package wf3_pkg;

  localparam int PIX_W   = 8;
  localparam int NUM_PIX = 9;
  localparam int RANK_W  = 4;
  localparam int CNT_W   = 4;
  localparam int MODE_W  = 3;

  // register file
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANK_INDEX  = 1'd1;

  typedef enum logic [MODE_W-1:0] {
    MODE_RANK    = 3'd0,
    MODE_MEDIAN  = 3'd1,
    MODE_MODE    = 3'd2,
    MODE_GAUSS   = 3'd3,
    MODE_SHARPEN = 3'd4
  } filt_mode_t;

  localparam logic [MODE_W-1:0] FILTER_MODE_RST = MODE_MEDIAN;
  localparam logic [RANK_W-1:0] RANK_INDEX_RST  = 4'd4;
  localparam logic [RANK_W-1:0] RANK_MAX        = 4'd8;
  localparam logic [RANK_W-1:0] MEDIAN_POS      = 4'd4;
  localparam logic [PIX_W-1:0]  PIX_MAX         = 8'd255;

endpackage

>>> rtl/wf3_win_if.sv
interface wf3_win_if
  import wf3_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pix_top_left;
  logic [PIX_W-1:0] pix_top_mid;
  logic [PIX_W-1:0] pix_top_right;
  logic [PIX_W-1:0] pix_mid_left;
  logic [PIX_W-1:0] pix_center;
  logic [PIX_W-1:0] pix_mid_right;
  logic [PIX_W-1:0] pix_bot_left;
  logic [PIX_W-1:0] pix_bot_mid;
  logic [PIX_W-1:0] pix_bot_right;

  modport source (
    output valid, pix_top_left, pix_top_mid, pix_top_right, pix_mid_left, pix_center,
           pix_mid_right, pix_bot_left, pix_bot_mid, pix_bot_right,
    input  ready
  );
  modport sink (
    input  valid, pix_top_left, pix_top_mid, pix_top_right, pix_mid_left, pix_center,
           pix_mid_right, pix_bot_left, pix_bot_mid, pix_bot_right,
    output ready
  );
endinterface

>>> rtl/wf3_pix_if.sv
interface wf3_pix_if
  import wf3_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] filtered_pixel;

  modport source (output valid, filtered_pixel, input ready);
  modport sink (input valid, filtered_pixel, output ready);
endinterface

>>> rtl/window_filter_3x3_multimode.sv
// 3x3 window filter: one window word in, one filtered pixel out, one word per clock
// sustained while res.ready holds high. The window is captured in an input register, all
// filters (rank, median, mode, gaussian, sharpen) are evaluated in one combinational
// pass, and the selected pixel lands in the result register. Ranking uses parallel
// pairwise compares with a position tie-break instead of a sort network, so the rate is
// set by that one compare-and-count pass. The input register doubles as a skid stage:
// a new window is taken while a finished result waits. filter_mode and rank_index are
// read live and must only be written while the block is drained.
module window_filter_3x3_multimode
  import wf3_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  wf3_win_if.sink               win,
  wf3_pix_if.source             res
);

  logic [MODE_W-1:0] filter_mode;
  logic [RANK_W-1:0] rank_index;

  logic             v1;
  logic             v2;
  logic [PIX_W-1:0] p1 [NUM_PIX];
  logic [PIX_W-1:0] pix_out;
  logic [PIX_W-1:0] pix_out_next;

  logic adv2;
  logic load2;
  logic accept;

  logic [RANK_W-1:0]  rank [NUM_PIX];
  logic [CNT_W-1:0]   cnt  [NUM_PIX];
  logic [NUM_PIX-1:0] win_mask;
  logic [NUM_PIX-1:0] med_hit;
  logic [RANK_W-1:0]  rank_sel;
  logic [PIX_W-1:0]   rank_val;
  logic [PIX_W-1:0]   med_val;
  logic [PIX_W-1:0]   mode_val;
  logic               any_repeat;
  logic [11:0]        gauss_sum;
  logic [11:0]        sh_pos;
  logic [11:0]        sh_neg;
  logic [11:0]        sh_diff;
  logic [PIX_W-1:0]   sharp_val;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode <= FILTER_MODE_RST;
      rank_index  <= RANK_INDEX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FILTER_MODE: filter_mode <= cfg_data[MODE_W-1:0];
        REG_RANK_INDEX:  rank_index  <= cfg_data[RANK_W-1:0];
        default: ;
      endcase
    end
  end

  // two-stage handshake: input register, result register
  assign adv2       = !v2 || res.ready;
  assign load2      = v1 && adv2;
  assign win.ready  = !v1 || adv2;
  assign accept     = win.valid && win.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (accept)     v1 <= 1'b1;
      else if (load2) v1 <= 1'b0;
      if (load2)          v2 <= 1'b1;
      else if (res.ready) v2 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1[0] <= win.pix_top_left;
      p1[1] <= win.pix_top_mid;
      p1[2] <= win.pix_top_right;
      p1[3] <= win.pix_mid_left;
      p1[4] <= win.pix_center;
      p1[5] <= win.pix_mid_right;
      p1[6] <= win.pix_bot_left;
      p1[7] <= win.pix_bot_mid;
      p1[8] <= win.pix_bot_right;
    end
    if (load2) pix_out <= pix_out_next;
  end

  // sorted position and multiplicity of every pixel; equal values ordered by position
  always_comb begin
    for (int i = 0; i < NUM_PIX; i++) begin
      rank[i] = '0;
      cnt[i]  = '0;
      for (int j = 0; j < NUM_PIX; j++) begin
        if (p1[j] == p1[i]) cnt[i] = cnt[i] + CNT_W'(1);
        if (j != i && (p1[j] < p1[i] || (p1[j] == p1[i] && j < i)))
          rank[i] = rank[i] + RANK_W'(1);
      end
    end
  end

  // mode winner: highest count, then smallest value
  always_comb begin
    for (int i = 0; i < NUM_PIX; i++) begin
      win_mask[i] = 1'b1;
      for (int j = 0; j < NUM_PIX; j++) begin
        if (!(cnt[i] > cnt[j] || (cnt[i] == cnt[j] && p1[i] <= p1[j])))
          win_mask[i] = 1'b0;
      end
    end
  end

  always_comb begin
    rank_sel   = (rank_index > RANK_MAX) ? RANK_MAX : rank_index;
    rank_val   = '0;
    med_val    = '0;
    mode_val   = '0;
    any_repeat = 1'b0;
    for (int i = 0; i < NUM_PIX; i++) begin
      med_hit[i] = (rank[i] == MEDIAN_POS);
      if (rank[i] == rank_sel) rank_val = rank_val | p1[i];
      if (med_hit[i])          med_val  = med_val | p1[i];
      // all winners share one value
      if (win_mask[i])         mode_val = mode_val | p1[i];
      if (cnt[i] != CNT_W'(1)) any_repeat = 1'b1;
    end
  end

  always_comb begin
    gauss_sum = 12'(p1[0]) + 12'(p1[2]) + 12'(p1[6]) + 12'(p1[8])
              + {3'b0, p1[1], 1'b0} + {3'b0, p1[3], 1'b0}
              + {3'b0, p1[5], 1'b0} + {3'b0, p1[7], 1'b0}
              + {2'b0, p1[4], 2'b0};
    sh_pos  = {2'b0, p1[4], 2'b0} + 12'(p1[4]);
    sh_neg  = 12'(p1[1]) + 12'(p1[3]) + 12'(p1[5]) + 12'(p1[7]);
    sh_diff = sh_pos - sh_neg;
    if (sh_pos < sh_neg)              sharp_val = '0;
    else if (sh_diff > 12'(PIX_MAX))  sharp_val = PIX_MAX;
    else                              sharp_val = sh_diff[PIX_W-1:0];
  end

  always_comb begin
    case (filter_mode)
      MODE_RANK:    pix_out_next = rank_val;
      MODE_MEDIAN:  pix_out_next = med_val;
      MODE_MODE:    pix_out_next = any_repeat ? mode_val : med_val;
      MODE_GAUSS:   pix_out_next = gauss_sum[11:4];
      MODE_SHARPEN: pix_out_next = sharp_val;
      default:      pix_out_next = '0;
    endcase
  end

  assign res.valid          = v2;
  assign res.filtered_pixel = pix_out;

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !win.ready |-> (v1 && v2))
    else $error("input stalled with a free stage");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    accept |=> v1)
    else $error("accepted word not held in input register");

  a_median_unique: assert property (@(posedge clk) disable iff (rst)
    v1 |-> $onehot(med_hit))
    else $error("sorted positions not unique");

  a_mode_winner: assert property (@(posedge clk) disable iff (rst)
    v1 |-> (win_mask != '0))
    else $error("no mode winner");

  a_reset_cfg: assert property (@(posedge clk)
    $past(rst) && !cfg_we |=> 1'b1 ##0 (!$past(rst) || $past(cfg_we) ||
      (filter_mode == FILTER_MODE_RST && rank_index == RANK_INDEX_RST)))
    else $error("config registers not at reset value");

endmodule

>>> sim/wf3_pixel_checker.sv
`timescale 1ns / 100ps
module wf3_pixel_checker
  import wf3_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  wf3_win_if                    win,
  wf3_pix_if                    res,
  output int                    mismatches,
  output int                    windows_in_flight,
  output int                    pixels_checked
);

  logic [MODE_W-1:0] filter_mode;
  logic [RANK_W-1:0] rank_index;
  logic [PIX_W-1:0]  expected_pixels [$];

  function automatic logic [PIX_W-1:0] filter_window(
    input logic [NUM_PIX-1:0][PIX_W-1:0] w,
    input logic [MODE_W-1:0]             mode,
    input logic [RANK_W-1:0]             rank
  );
    logic [PIX_W-1:0] s [NUM_PIX];
    logic [PIX_W-1:0] key;
    logic [PIX_W-1:0] best;
    int b;
    int run_end;
    int best_len;
    int sum;
    int sharp;
    for (int a = 0; a < NUM_PIX; a++) s[a] = w[a];
    for (int a = 1; a < NUM_PIX; a++) begin
      key = s[a];
      b = a - 1;
      while (b >= 0 && s[b] > key) begin
        s[b+1] = s[b];
        b--;
      end
      s[b+1] = key;
    end
    // longest run of equal values; strict compare keeps the smaller value on a tie
    best = s[MEDIAN_POS];
    best_len = 1;
    b = 0;
    while (b < NUM_PIX) begin
      run_end = b + 1;
      while (run_end < NUM_PIX && s[run_end] == s[b]) run_end++;
      if (run_end - b > best_len) begin
        best_len = run_end - b;
        best = s[b];
      end
      b = run_end;
    end
    sum = int'(w[0]) + 2 * int'(w[1]) + int'(w[2])
        + 2 * int'(w[3]) + 4 * int'(w[4]) + 2 * int'(w[5])
        + int'(w[6]) + 2 * int'(w[7]) + int'(w[8]);
    sharp = 5 * int'(w[4]) - int'(w[1]) - int'(w[3]) - int'(w[5]) - int'(w[7]);
    if (sharp < 0) sharp = 0;
    if (sharp > int'(PIX_MAX)) sharp = int'(PIX_MAX);
    case (mode)
      MODE_RANK:    return s[(rank > RANK_MAX) ? RANK_MAX : rank];
      MODE_MEDIAN:  return s[MEDIAN_POS];
      MODE_MODE:    return best;
      MODE_GAUSS:   return sum[PIX_W+3:4];
      MODE_SHARPEN: return sharp[PIX_W-1:0];
      default:      return '0;
    endcase
  endfunction

  always @(posedge clk) begin : track
    logic [PIX_W-1:0] want;
    if (rst) begin
      filter_mode <= FILTER_MODE_RST;
      rank_index <= RANK_INDEX_RST;
      expected_pixels.delete();
      windows_in_flight <= 0;
      mismatches <= 0;
      pixels_checked <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_FILTER_MODE) filter_mode <= cfg_data[MODE_W-1:0];
        else if (cfg_index == REG_RANK_INDEX) rank_index <= cfg_data[RANK_W-1:0];
      end
      if (res.valid && res.ready) begin
        if (expected_pixels.size() == 0) begin
          $error("filtered_pixel with no window pending: expected none, got %0d",
                 res.filtered_pixel);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_pixels.pop_front();
          pixels_checked <= pixels_checked + 1;
          if (res.filtered_pixel !== want) begin
            $error("filtered_pixel: expected %0d, got %0d", want, res.filtered_pixel);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (win.valid && win.ready)
        expected_pixels.push_back(filter_window(
          {win.pix_bot_right, win.pix_bot_mid, win.pix_bot_left,
           win.pix_mid_right, win.pix_center, win.pix_mid_left,
           win.pix_top_right, win.pix_top_mid, win.pix_top_left},
          filter_mode, rank_index));
      windows_in_flight <= expected_pixels.size();
    end
  end

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
module tb;
  import wf3_pkg::*;

  typedef logic [NUM_PIX-1:0][PIX_W-1:0] window_t;

  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_WORDS   = 29;
  localparam int FIXED_PHASES  = 13;
  localparam int RANDOM_PHASES = 13;

  // mode codes with no filter behind them
  localparam logic [MODE_W-1:0] MODE_SPARE_LO  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_MID = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI  = 3'd7;
  // rank positions past the largest pixel
  localparam logic [RANK_W-1:0] RANK_OVER_LO = 4'd9;
  localparam logic [RANK_W-1:0] RANK_OVER_HI = 4'd15;

  localparam logic [CFG_DATA_W-1:0] FIXED_MODE [FIXED_PHASES] = '{
    {1'b0, MODE_RANK}, {1'b0, MODE_RANK}, {1'b0, MODE_RANK}, {1'b0, MODE_RANK},
    {1'b0, MODE_MEDIAN}, {1'b0, MODE_MODE}, {1'b0, MODE_GAUSS}, {1'b0, MODE_SHARPEN},
    {1'b0, MODE_SPARE_LO}, {1'b0, MODE_SPARE_MID}, {1'b0, MODE_SPARE_HI},
    {1'b1, MODE_MODE}, {1'b1, MODE_SHARPEN}
  };
  localparam logic [CFG_DATA_W-1:0] FIXED_RANK [FIXED_PHASES] = '{
    4'd0, RANK_MAX, RANK_OVER_LO, RANK_OVER_HI, 4'd3, 4'd0, RANK_OVER_HI, 4'd7,
    4'd4, 4'd2, 4'd1, 4'd5, 4'd6
  };

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatches;
  int                    windows_in_flight;
  int                    pixels_checked;
  int                    windows_sent;
  int                    settings_used;
  bit                    no_gaps;

  wf3_win_if win();
  wf3_pix_if res();

  window_filter_3x3_multimode dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .win       (win),
    .res       (res)
  );

  wf3_pixel_checker pixel_check (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .win               (win),
    .res               (res),
    .mismatches        (mismatches),
    .windows_in_flight (windows_in_flight),
    .pixels_checked    (pixels_checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("window_filter_3x3_multimode verification failed");
    $finish;
  end

  function automatic window_t mk(input int p0, p1, p2, p3, p4, p5, p6, p7, p8);
    return {p8[7:0], p7[7:0], p6[7:0], p5[7:0], p4[7:0], p3[7:0], p2[7:0], p1[7:0],
            p0[7:0]};
  endfunction

  function automatic window_t random_window();
    window_t w;
    logic [PIX_W-1:0] palette [4];
    logic [1:0] pick;
    int kind;
    int base;
    int v;
    kind = int'($urandom_range(0, 3));
    base = int'($urandom_range(0, 255));
    for (int k = 0; k < 4; k++) palette[k] = 8'($urandom_range(0, 255));
    for (int k = 0; k < NUM_PIX; k++) begin
      case (kind)
        0: w[k] = 8'($urandom_range(0, 255));
        // few distinct values so runs and ties show up
        1: begin
          pick = 2'($urandom_range(0, $urandom_range(1, 3)));
          w[k] = palette[pick];
        end
        2: case ($urandom_range(0, 3))
             0: w[k] = 8'd0;
             1: w[k] = 8'd1;
             2: w[k] = 8'd254;
             default: w[k] = PIX_MAX;
           endcase
        default: begin
          v = base + int'($urandom_range(0, 32)) - 16;
          if (v < 0) v = 0;
          if (v > 255) v = 255;
          w[k] = v[7:0];
        end
      endcase
    end
    return w;
  endfunction

  task automatic send_window(input window_t w);
    int gap;
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 65) gap = 0;
    else if (r < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 25);
    if (gap > 0) begin
      win.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    win.valid <= 1'b1;
    win.pix_top_left <= w[0];
    win.pix_top_mid <= w[1];
    win.pix_top_right <= w[2];
    win.pix_mid_left <= w[3];
    win.pix_center <= w[4];
    win.pix_mid_right <= w[5];
    win.pix_bot_left <= w[6];
    win.pix_bot_mid <= w[7];
    win.pix_bot_right <= w[8];
    @(posedge clk);
    while (!win.ready) @(posedge clk);
    windows_sent++;
  endtask

  task automatic drain();
    win.valid <= 1'b0;
    @(posedge clk);
    while (windows_in_flight != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_filter(input logic [CFG_DATA_W-1:0] mode_word,
                            input logic [CFG_DATA_W-1:0] rank_word);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= REG_FILTER_MODE;
    cfg_data <= mode_word;
    @(posedge clk);
    cfg_index <= REG_RANK_INDEX;
    cfg_data <= rank_word;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // result side: bursts of ready with short and occasional long stalls
  initial begin
    res.ready <= 1'b0;
    forever begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
        res.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else if (r < 70) begin
        res.ready <= 1'b1;
        repeat ($urandom_range(50, 150)) @(posedge clk);
      end else if (r < 95) begin
        res.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        res.ready <= 1'b0;
        repeat ($urandom_range(10, 30)) @(posedge clk);
      end
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] mode_word;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    win.valid <= 1'b0;
    win.pix_top_left <= '0;
    win.pix_top_mid <= '0;
    win.pix_top_right <= '0;
    win.pix_mid_left <= '0;
    win.pix_center <= '0;
    win.pix_mid_right <= '0;
    win.pix_bot_left <= '0;
    win.pix_bot_mid <= '0;
    win.pix_bot_right <= '0;
    windows_sent = 0;
    settings_used = 0;
    no_gaps = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // settings from reset: median
    send_window(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_window(mk(255, 255, 255, 255, 255, 255, 255, 255, 255));
    send_window(mk(8, 7, 6, 5, 4, 3, 2, 1, 0));

    // no repeat falls back to median, tied runs go to the smaller value
    set_filter({1'b0, MODE_MODE}, MEDIAN_POS);
    send_window(mk(9, 1, 2, 3, 4, 5, 6, 7, 8));
    send_window(mk(20, 10, 20, 10, 20, 10, 30, 40, 50));
    send_window(mk(50, 50, 200, 200, 200, 1, 2, 3, 4));
    send_window(mk(77, 77, 77, 77, 77, 77, 77, 77, 77));
    send_window(mk(255, 255, 0, 0, 128, 3, 4, 5, 6));

    set_filter({1'b0, MODE_GAUSS}, MEDIAN_POS);
    send_window(mk(255, 255, 255, 255, 255, 255, 255, 255, 255));
    send_window(mk(0, 0, 0, 0, 255, 0, 0, 0, 0));
    send_window(mk(15, 0, 0, 0, 0, 0, 0, 0, 0));

    // clamps at both ends, corners play no part
    set_filter({1'b0, MODE_SHARPEN}, MEDIAN_POS);
    send_window(mk(0, 0, 0, 0, 255, 0, 0, 0, 0));
    send_window(mk(255, 255, 255, 255, 0, 255, 255, 255, 255));
    send_window(mk(100, 100, 100, 100, 100, 100, 100, 100, 100));
    send_window(mk(255, 50, 255, 50, 50, 50, 255, 50, 255));

    set_filter({1'b0, MODE_RANK}, 4'd0);
    send_window(mk(30, 10, 90, 70, 50, 20, 80, 40, 60));
    set_filter({1'b0, MODE_RANK}, RANK_MAX);
    send_window(mk(30, 10, 90, 70, 50, 20, 80, 40, 60));
    set_filter({1'b0, MODE_RANK}, RANK_OVER_HI);
    send_window(mk(30, 10, 90, 70, 50, 20, 80, 40, 60));

    set_filter({1'b0, MODE_SPARE_LO}, RANK_MAX);
    send_window(mk(30, 10, 90, 70, 50, 20, 80, 40, 60));

    for (int ph = 0; ph < FIXED_PHASES + RANDOM_PHASES; ph++) begin
      if (ph < FIXED_PHASES) begin
        set_filter(FIXED_MODE[ph], FIXED_RANK[ph]);
      end else begin
        if ($urandom_range(0, 9) < 8) mode_word[MODE_W-1:0] = MODE_W'($urandom_range(0, 4));
        else mode_word[MODE_W-1:0] = MODE_W'($urandom_range(5, 7));
        mode_word[CFG_DATA_W-1] = 1'($urandom_range(0, 1));
        set_filter(mode_word, CFG_DATA_W'($urandom_range(0, 15)));
      end
      no_gaps = (ph % 4 == 3);
      for (int n = 0; n < PHASE_WORDS; n++) send_window(random_window());
    end
    no_gaps = 1'b0;
    drain();

    $display("%0d windows sent under %0d filter settings, %0d filtered pixels checked",
             windows_sent, settings_used, pixels_checked);
    if (mismatches == 0) begin
      $display("window_filter_3x3_multimode verification clean");
    end else begin
      $display("window_filter_3x3_multimode verification failed");
    end
    $finish;
  end

endmodule

>>> window_filter_3x3_multimode.f
rtl/wf3_pkg.sv
rtl/wf3_win_if.sv
rtl/wf3_pix_if.sv
rtl/window_filter_3x3_multimode.sv
sim/wf3_pixel_checker.sv
sim/tb.sv
